// ===== sv/rtat_pkg.sv =====
// Shared types, constants and reset values for the relay toggle actuation timer.
package rtat_pkg;

  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned LATENCY_BITS = 32;

  typedef logic [TIME_BITS-1:0]    tick_t;
  typedef logic [CFG_BITS-1:0]     cfg_t;
  typedef logic [LATENCY_BITS-1:0] latency_t;

  typedef enum logic {
    CFG_PRESS_LOCKOUT = 1'b0,
    CFG_SETTLE        = 1'b1
  } cfg_idx_e;

  localparam cfg_t PRESS_LOCKOUT_RST = 16'd150;
  localparam cfg_t SETTLE_RST        = 16'd20;

  typedef struct packed {
    logic button_level;
    logic contact_level;
  } item_t;

  typedef struct packed {
    logic     relay_drive;
    logic     report_valid;
    logic     report_on;
    latency_t latency_ticks;
    logic     confirmed_level;
  } result_t;

  // press_time doubles as command time: both are stamped by the same accepted press
  typedef struct packed {
    tick_t tick_now;
    logic  button_before;
    tick_t press_time;
    logic  drive_on;
    logic  command_issued;
    logic  contact_before;
    tick_t edge_time;
    logic  contact_confirmed;
    logic  primed;
  } state_t;

  localparam state_t STATE_RST = '{
    tick_now:          '0,
    button_before:     1'b1,
    press_time:        '0,
    drive_on:          1'b0,
    command_issued:    1'b0,
    contact_before:    1'b1,
    edge_time:         '0,
    contact_confirmed: 1'b1,
    primed:            1'b0
  };

endpackage

// ===== sv/rtat_if.sv =====
// Valid/ready channel interfaces for input ticks and result items.
interface rtat_item_if;
  import rtat_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtat_result_if;
  import rtat_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rtat_step.sv =====
// Per-tick next-state and result logic of the relay toggle actuation timer.
module rtat_step (
  input  rtat_pkg::state_t  state_i,
  input  rtat_pkg::item_t   item_i,
  input  rtat_pkg::cfg_t    lockout_i,
  input  rtat_pkg::cfg_t    settle_i,
  output rtat_pkg::state_t  state_o,
  output rtat_pkg::result_t result_o
);
  import rtat_pkg::*;

  tick_t now;
  tick_t since_press;
  tick_t since_edge;
  tick_t edge_t;
  logic  press;
  logic  take;
  logic  contact_prev;
  logic  conf;
  logic  edge_seen;
  logic  change;
  logic  report;

  assign now         = state_i.tick_now;
  assign since_press = tick_t'(now - state_i.press_time);
  assign press       = state_i.button_before & ~item_i.button_level;
  assign take        = press && (since_press >= tick_t'(lockout_i));

  // first sample primes the feedback trackers, so no edge is seen on it
  assign contact_prev = state_i.primed ? state_i.contact_before : item_i.contact_level;
  assign conf      = state_i.primed ? state_i.contact_confirmed : item_i.contact_level;
  assign edge_seen = item_i.contact_level != contact_prev;
  assign edge_t    = edge_seen ? now : state_i.edge_time;
  assign since_edge = tick_t'(now - edge_t);
  assign change    = (since_edge >= tick_t'(settle_i)) && (item_i.contact_level != conf);

  always_comb begin
    state_o                   = state_i;
    state_o.tick_now          = tick_t'(now + tick_t'(1));
    state_o.button_before     = item_i.button_level;
    state_o.primed            = 1'b1;
    state_o.contact_before    = item_i.contact_level;
    state_o.edge_time         = edge_t;
    state_o.contact_confirmed = change ? item_i.contact_level : conf;
    if (take) begin
      state_o.press_time     = now;
      state_o.drive_on       = ~state_i.drive_on;
      state_o.command_issued = 1'b1;
    end
  end

  assign report = change & state_o.command_issued;

  always_comb begin
    result_o.relay_drive     = state_o.drive_on;
    result_o.report_valid    = report;
    result_o.report_on       = report & ~item_i.contact_level;
    result_o.latency_ticks   = report ? latency_t'(tick_t'(edge_t - state_o.press_time)) : '0;
    result_o.confirmed_level = state_o.contact_confirmed;
  end

endmodule

// ===== sv/relay_toggle_actuation_timer_core.sv =====
// Relay toggle with press lockout, contact settle filter and actuation latency report.
// One input transfer is one tick and yields exactly one result transfer. A tick can be
// taken every clock cycle: the state registers and the result register update in the
// cycle of the transfer, so the sustained rate is one tick per cycle, limited only by
// the result register. A tick is accepted whenever that register is empty or being
// drained in the same cycle. Configuration writes take effect on the next tick.
module relay_toggle_actuation_timer_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  rtat_pkg::cfg_idx_e    cfg_idx_i,
  input  rtat_pkg::cfg_t        cfg_data_i,
  rtat_item_if.sink             item_i,
  rtat_result_if.source         result_o
);
  import rtat_pkg::*;

  cfg_t    lockout_q;
  cfg_t    settle_q;
  state_t  state_q;
  state_t  state_d;
  result_t result_d;
  result_t result_q;
  logic    out_valid_q;
  logic    out_valid_d;
  logic    accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= PRESS_LOCKOUT_RST;
      settle_q  <= SETTLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRESS_LOCKOUT: lockout_q <= cfg_data_i;
        CFG_SETTLE:        settle_q  <= cfg_data_i;
      endcase
    end
  end

  rtat_step u_step (
    .state_i   (state_q),
    .item_i    (item_i.data),
    .lockout_i (lockout_q),
    .settle_i  (settle_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  assign item_i.ready = ~out_valid_q | result_o.ready;
  assign accept       = item_i.valid & item_i.ready;
  assign out_valid_d  = accept | (out_valid_q & ~result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RST;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = result_q;

  // tick counter advances by exactly one per transfer
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q.tick_now == tick_t'($past(state_q.tick_now) + tick_t'(1)))
    else $error("tick counter did not advance on transfer");

  // drive only toggles on an accepted tick
  a_drive_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(state_q.drive_on))
    else $error("relay drive changed without a transfer");

  // a report implies a command was issued
  a_report_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.report_valid) |-> state_q.command_issued)
    else $error("report without any issued command");

  // a reported on state is the inverse of the confirmed contact level it reports
  a_report_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.report_valid) |-> (result_q.report_on != result_q.confirmed_level))
    else $error("reported state disagrees with confirmed level");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> item_i.ready)
    else $error("input stalled with empty result register");

endmodule

// ===== tb/relay_toggle_actuation_timer_checker.sv =====
// Transfer monitor and cycle-free predictor for the relay toggle actuation timer.
module relay_toggle_actuation_timer_checker
  import rtat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  cfg_t        cfg_data_i,
  rtat_item_if        item_i,
  rtat_result_if      result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned ticks_o,
  output int unsigned presses_o,
  output int unsigned reports_o
);

  // predictor copy of the timing registers and tick state
  cfg_t  lockout_ticks;
  cfg_t  settle_need;
  tick_t now_tick;
  logic  btn_prev;
  tick_t last_press;
  logic  coil_on;
  tick_t cmd_time;
  logic  cmd_seen;
  logic  fb_prev;
  tick_t fb_edge_time;
  logic  fb_confirmed;
  logic  fb_primed;

  result_t     expected_q[$];
  int unsigned mismatches;
  int unsigned ticks_seen;
  int unsigned presses_seen;
  int unsigned reports_seen;

  function automatic result_t advance_tick(item_t it);
    result_t r;
    tick_t   now;
    r   = '0;
    now = now_tick;
    // falling button edge, gated by the press lockout
    if (btn_prev && !it.button_level &&
        tick_t'(now - last_press) >= tick_t'(lockout_ticks)) begin
      last_press = now;
      cmd_time   = now;
      coil_on    = ~coil_on;
      cmd_seen   = 1'b1;
      presses_seen++;
    end
    btn_prev = it.button_level;
    // first sample primes the feedback trackers, so no edge is seen on it
    if (!fb_primed) begin
      fb_prev      = it.contact_level;
      fb_confirmed = it.contact_level;
      fb_primed    = 1'b1;
    end
    if (it.contact_level != fb_prev) begin
      fb_prev      = it.contact_level;
      fb_edge_time = now;
    end
    if (tick_t'(now - fb_edge_time) >= tick_t'(settle_need) &&
        it.contact_level != fb_confirmed) begin
      fb_confirmed = it.contact_level;
      if (cmd_seen) begin
        r.report_valid  = 1'b1;
        r.report_on     = ~fb_confirmed;
        r.latency_ticks = latency_t'(fb_edge_time - cmd_time);
      end
    end
    now_tick          = now + 1'b1;
    r.relay_drive     = coil_on;
    r.confirmed_level = fb_confirmed;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t seen;
    if (!rst_ni) begin
      lockout_ticks = PRESS_LOCKOUT_RST;
      settle_need   = SETTLE_RST;
      now_tick      = '0;
      btn_prev      = 1'b1;
      last_press    = '0;
      coil_on       = 1'b0;
      cmd_time      = '0;
      cmd_seen      = 1'b0;
      fb_prev       = 1'b1;
      fb_edge_time  = '0;
      fb_confirmed  = 1'b1;
      fb_primed     = 1'b0;
      expected_q.delete();
      mismatches    = 0;
      ticks_seen    = 0;
      presses_seen  = 0;
      reports_seen  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      ticks_o      <= 0;
      presses_o    <= 0;
      reports_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PRESS_LOCKOUT: lockout_ticks = cfg_data_i;
          CFG_SETTLE:        settle_need   = cfg_data_i;
          default: ;
        endcase
      end
      // push before pop so a same-cycle result would still find its expectation
      if (item_i.valid && item_i.ready) begin
        expected_q.push_back(advance_tick(item_i.data));
        ticks_seen++;
      end
      if (result_i.valid && result_i.ready) begin
        seen = result_i.data;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, actual %0h", $time, seen);
        end else begin
          want = expected_q.pop_front();
          if (want.report_valid) reports_seen++;
          check_field("relay_drive", 32'(want.relay_drive), 32'(seen.relay_drive));
          check_field("report_valid", 32'(want.report_valid), 32'(seen.report_valid));
          check_field("report_on", 32'(want.report_on), 32'(seen.report_on));
          check_field("latency_ticks", want.latency_ticks, seen.latency_ticks);
          check_field("confirmed_level", 32'(want.confirmed_level),
                      32'(seen.confirmed_level));
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_q.size();
      ticks_o      <= ticks_seen;
      presses_o    <= presses_seen;
      reports_o    <= reports_seen;
    end
  end

endmodule

// ===== tb/relay_toggle_actuation_timer_core_tb.sv =====
// Testbench top: clock, reset, tick stimulus, result back-pressure and verdict.
module relay_toggle_actuation_timer_core_tb;
  import rtat_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     cfg_we_i;
  cfg_idx_e cfg_idx_i;
  cfg_t     cfg_data_i;

  rtat_item_if   item_ch ();
  rtat_result_if result_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned ticks_done;
  int unsigned presses_done;
  int unsigned reports_done;
  int unsigned settings_used;

  // sender idle pattern, stretches of random gaps and of back-to-back ticks
  int unsigned tx_run_left;
  logic        tx_calm;
  logic        cur_btn;
  logic        cur_fb;

  // receiver stall pattern
  int unsigned rx_hold;
  int unsigned rx_run_left;
  logic        rx_calm;

  relay_toggle_actuation_timer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_ch.sink),
    .result_o   (result_ch.source)
  );

  relay_toggle_actuation_timer_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_i       (item_ch),
    .result_i     (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .ticks_o      (ticks_done),
    .presses_o    (presses_done),
    .reports_o    (reports_done)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result sink: after each transfer drops ready for a random stall or, in calm stretches, keeps it high
  initial begin
    result_ch.ready <= 1'b0;
    rx_hold     = 0;
    rx_run_left = 0;
    rx_calm     = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (result_ch.valid && result_ch.ready) begin
        if (rx_run_left == 0) begin
          rx_calm     = ($urandom_range(0, 3) == 0);
          rx_run_left = $urandom_range(20, 150);
        end
        rx_run_left--;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 7);
        if (rx_hold > 0) result_ch.ready <= 1'b0;
      end else if (!result_ch.ready) begin
        if (rx_hold > 0) rx_hold--;
        if (rx_hold == 0) result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic btn, input logic fb);
    int unsigned gap;
    if (tx_run_left == 0) begin
      tx_calm     = ($urandom_range(0, 3) == 0);
      tx_run_left = $urandom_range(20, 150);
    end
    tx_run_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= '{button_level: btn, contact_level: fb};
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  // stop sending and wait until every outstanding tick has produced its result
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic load_timing(input cfg_t lockout, input cfg_t settle);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PRESS_LOCKOUT;
    cfg_data_i <= lockout;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SETTLE;
    cfg_data_i <= settle;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  // button and contact move as runs of random length scaled to the timing
  // registers, with short contact bounce and occasional single-tick glitches
  task automatic shaped_ticks(input int unsigned n, input int unsigned lock_span,
                              input int unsigned settle_span);
    int unsigned btn_left;
    int unsigned fb_left;
    btn_left = $urandom_range(1, lock_span);
    fb_left  = $urandom_range(1, settle_span);
    for (int unsigned k = 0; k < n; k++) begin
      if (btn_left == 0) begin
        cur_btn  = ~cur_btn;
        btn_left = $urandom_range(1, lock_span);
      end
      if (fb_left == 0) begin
        cur_fb  = ~cur_fb;
        fb_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2)
                                              : $urandom_range(1, settle_span);
      end
      if ($urandom_range(0, 15) == 0)
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        send_tick(cur_btn, cur_fb);
      btn_left--;
      fb_left--;
    end
  endtask

  task automatic timing_phase(input cfg_t lockout, input cfg_t settle, input int unsigned n);
    int unsigned lspan;
    int unsigned sspan;
    load_timing(lockout, settle);
    lspan = ((lockout > 200) ? 200 : int'(lockout)) + 3;
    sspan = 2 * ((settle > 60) ? 60 : int'(settle)) + 3;
    shaped_ticks(n, lspan, sspan);
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_PRESS_LOCKOUT;
    cfg_data_i      <= '0;
    item_ch.valid   <= 1'b0;
    item_ch.data    <= '{button_level: 1'b1, contact_level: 1'b1};
    tx_run_left     = 0;
    tx_calm         = 1'b0;
    settings_used   = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset timing: first sample primes contact low with a press that the
    // lockout rejects, then a contact change confirms with no command issued
    send_tick(1'b0, 1'b0);
    repeat (2) send_tick(1'b1, 1'b0);
    repeat (22) send_tick(1'b1, 1'b1);
    cur_btn = 1'b1;
    cur_fb  = 1'b1;
    shaped_ticks(280, 153, 43);

    // zero lockout and zero settle: every falling edge toggles, every edge confirms
    load_timing(16'd0, 16'd0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    cur_btn = 1'b0;
    cur_fb  = 1'b0;

    // largest values: no press passes the lockout, nothing settles
    load_timing(16'hFFFF, 16'hFFFF);
    shaped_ticks(30, 4, 6);

    timing_phase(16'd0, 16'd0, 200);
    timing_phase(16'd1, 16'd1, 200);
    repeat (3) timing_phase(cfg_t'($urandom_range(0, 40)), cfg_t'($urandom_range(0, 30)), 250);
    timing_phase(16'hFFFF, 16'd0, 150);
    timing_phase(16'd0, 16'hFFFF, 100);
    timing_phase(PRESS_LOCKOUT_RST, SETTLE_RST, 100);
    drain_results();
    shaped_ticks(100, 153, 43);

    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d ticks over %0d timing settings", ticks_done, settings_used);
    $display("  %0d presses toggled the relay, %0d confirmed changes reported latency",
             presses_done, reports_done);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/rtat_pkg.sv
sv/rtat_if.sv
sv/rtat_step.sv
sv/relay_toggle_actuation_timer_core.sv
tb/relay_toggle_actuation_timer_checker.sv
tb/relay_toggle_actuation_timer_core_tb.sv
